>>> rtl/core/kji_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyframe joint interpolator package
// Fixed field widths, action codes and the controller state type of the
// interpolator; its port checker and the testbench share the widths and codes.
// ----------------------------------------------------------------------------
package kji_pkg;

  // Widths of the stream fields that do not scale with the block parameters.
  localparam int ACTION_W      = 3;
  localparam int INDEX_W       = 3;
  localparam int DUR_IN_W      = 32;
  localparam int TIME_IN_W     = 32;
  localparam int JOINT_ID_W    = 3;
  localparam int PHASE_COUNT_W = 4;

  localparam logic [PHASE_COUNT_W-1:0] PHASE_COUNT_RESET = 4'd5;

  // Item kinds carried on the input tuser.
  localparam logic [ACTION_W-1:0] ACT_LOAD_KEY   = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_LOAD_START = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_LOAD_DUR   = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_START      = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_TICK       = 3'd4;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EVAL,
    ST_COPY_RD,
    ST_COPY_WR,
    ST_FETCH,
    ST_LOAD,
    ST_MUL,
    ST_DIV,
    ST_RES,
    ST_OUT
  } kji_state_t;

endpackage

>>> rtl/core/keyframe_joint_interpolator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyframe joint interpolator
// Timed keyframe player that commands LEG_COUNT*JOINTS_PER_LEG joints by
// linear interpolation between a start pose and the keyframe of the current
// phase.
// ----------------------------------------------------------------------------
// Load and start items give no result. A tick runs one evaluation step, then
// copies the finished keyframe into the start pose joint by joint when the
// phase advances to a phase still in use, then per joint fetches and loads;
// while interpolating it multiplies, divides and forms the result before the
// output step, but goes straight to the output step when the trajectory is
// done or the phase duration is zero. The output step waits while the output
// side stalls. Multiply and divide use one shared shift-add multiplier and one
// restoring divider, each retiring one bit per cycle. The next item is taken
// as soon as the last result of a tick sits in the output register.
// ----------------------------------------------------------------------------
module keyframe_joint_interpolator #(
  parameter int LEG_COUNT      = 4,
  parameter int JOINTS_PER_LEG = 2,
  parameter int MAX_PHASES     = 8,
  parameter int ANGLE_WIDTH    = 16,
  parameter int TIME_WIDTH     = 32,
  localparam int S_FIELDS_W = 2 * kji_pkg::INDEX_W + ANGLE_WIDTH
                              + kji_pkg::DUR_IN_W + kji_pkg::TIME_IN_W,
  localparam int S_DATA_W   = ((S_FIELDS_W + 7) / 8) * 8,
  localparam int M_FIELDS_W = kji_pkg::JOINT_ID_W + ANGLE_WIDTH,
  localparam int M_DATA_W   = ((M_FIELDS_W + 7) / 8) * 8
) (
  input  logic                               clk,
  input  logic                               rst,
  // Configuration: phase_count
  input  logic                               cfg_wr_en,
  input  logic [kji_pkg::PHASE_COUNT_W-1:0]  cfg_wr_data,
  // Input stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // tdata: phase_index, joint_index, angle_value, duration_value, time_now
  input  logic [S_DATA_W-1:0]                s_axis_tdata,
  // tuser: action
  input  logic [kji_pkg::ACTION_W-1:0]       s_axis_tuser,
  // Output stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // tdata: joint_id, joint_angle
  output logic [M_DATA_W-1:0]                m_axis_tdata,
  // tlast: last_joint
  output logic                               m_axis_tlast
);

  localparam int JOINT_COUNT = LEG_COUNT * JOINTS_PER_LEG;
  localparam int JIW         = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;
  localparam int PIW         = $clog2(MAX_PHASES);
  localparam int CPW         = $clog2(MAX_PHASES + 1);
  localparam int AW          = ANGLE_WIDTH;
  localparam int TW          = TIME_WIDTH;
  localparam int CNTW        = $clog2(ANGLE_WIDTH);
  localparam int KF_DEPTH    = 2 ** (PIW + JIW);
  localparam int IW          = kji_pkg::INDEX_W;

  localparam logic [JIW-1:0]  LAST_JOINT = JIW'(JOINT_COUNT - 1);
  localparam logic [CNTW-1:0] LAST_BIT   = CNTW'(ANGLE_WIDTH - 1);

  // Unpacked input fields.
  logic [IW-1:0]                  in_phase;
  logic [IW-1:0]                  in_joint;
  logic [AW-1:0]                  in_angle;
  logic [kji_pkg::DUR_IN_W-1:0]   in_dur;
  logic [kji_pkg::TIME_IN_W-1:0]  in_time;

  assign in_phase = s_axis_tdata[IW-1:0];
  assign in_joint = s_axis_tdata[2*IW-1:IW];
  assign in_angle = s_axis_tdata[2*IW +: AW];
  assign in_dur   = s_axis_tdata[2*IW+AW +: kji_pkg::DUR_IN_W];
  assign in_time  = s_axis_tdata[2*IW+AW+kji_pkg::DUR_IN_W +: kji_pkg::TIME_IN_W];

  // Control registers.
  kji_pkg::kji_state_t                state, state_next;
  logic [kji_pkg::PHASE_COUNT_W-1:0]  phase_count;
  logic [CPW-1:0]                     current_phase;
  logic [TW-1:0]                      phase_start_time;

  // Payload registers.
  logic [TW-1:0]   tick_time;
  logic [TW-1:0]   elapsed;
  logic            hold;
  logic            neg;
  logic [JIW-1:0]  joint;
  logic [CNTW-1:0] cnt;
  logic [TW-1:0]   hi;
  logic [AW-1:0]   lo;
  logic [AW-1:0]   res_angle;
  logic [AW-1:0]   rd_data;
  logic [kji_pkg::JOINT_ID_W-1:0] out_id;
  logic [AW-1:0]   out_angle;

  // Stores.
  logic [AW-1:0] kf_mem     [KF_DEPTH];
  logic [TW-1:0] durations  [MAX_PHASES];
  logic [AW-1:0] start_pose [JOINT_COUNT];

  // Handshake and strobes.
  logic            accept;
  logic            phase_ok;
  logic            joint_ok;
  logic            out_free;
  logic            out_load;
  logic            rd_en;
  logic [PIW-1:0]  rd_phase;
  logic [PIW+JIW-1:0] rd_addr;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign phase_ok = int'(in_phase) < MAX_PHASES;
  assign joint_ok = int'(in_joint) < JOINT_COUNT;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  // Phase count taken as saturated to 1..MAX_PHASES.
  logic [CPW-1:0] count_sat;
  always_comb begin
    if (phase_count == '0) begin
      count_sat = CPW'(1);
    end else if (int'(phase_count) > MAX_PHASES) begin
      count_sat = CPW'(MAX_PHASES);
    end else begin
      count_sat = CPW'(phase_count);
    end
  end

  // Phase evaluation for a tick.
  logic [TW-1:0]  elapsed_now;
  logic [TW-1:0]  cur_dur;
  logic [CPW-1:0] cur_plus;
  logic           past_end;
  logic           overrun;
  logic           finishing;
  logic           direct;

  assign elapsed_now = tick_time - phase_start_time;
  assign cur_dur     = durations[PIW'(current_phase)];
  assign cur_plus    = current_phase + 1'b1;
  assign past_end    = current_phase >= count_sat;
  assign overrun     = elapsed_now > cur_dur;
  assign finishing   = cur_plus >= count_sat;
  assign direct      = hold || (cur_dur == '0);

  // Distance between start and destination angles.
  logic signed [AW:0] s_ext;
  logic signed [AW:0] d_ext;
  logic signed [AW:0] diff;
  logic signed [AW:0] diff_neg;
  logic [AW-1:0]      abs_diff;

  assign s_ext    = {start_pose[joint][AW-1], start_pose[joint]};
  assign d_ext    = {rd_data[AW-1], rd_data};
  assign diff     = d_ext - s_ext;
  assign diff_neg = -diff;
  assign abs_diff = diff[AW] ? diff_neg[AW-1:0] : diff[AW-1:0];

  // One step of the shift-add multiplier.
  logic [TW:0] mul_sum;
  assign mul_sum = {1'b0, hi} + (lo[0] ? {1'b0, elapsed} : '0);

  // One step of the restoring divider.
  logic [TW:0] div_t;
  logic [TW:0] div_r;
  logic        div_ge;
  assign div_t  = {hi, lo[AW-1]};
  assign div_ge = div_t >= {1'b0, cur_dur};
  assign div_r  = div_t - {1'b0, cur_dur};

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      kji_pkg::ST_IDLE: begin
        if (accept && s_axis_tuser == kji_pkg::ACT_TICK) begin
          state_next = kji_pkg::ST_EVAL;
        end
      end
      kji_pkg::ST_EVAL: begin
        if (!past_end && overrun && !finishing) begin
          state_next = kji_pkg::ST_COPY_RD;
        end else begin
          state_next = kji_pkg::ST_FETCH;
        end
      end
      kji_pkg::ST_COPY_RD: state_next = kji_pkg::ST_COPY_WR;
      kji_pkg::ST_COPY_WR: begin
        state_next = (joint == LAST_JOINT) ? kji_pkg::ST_FETCH : kji_pkg::ST_COPY_RD;
      end
      kji_pkg::ST_FETCH: state_next = kji_pkg::ST_LOAD;
      kji_pkg::ST_LOAD: begin
        state_next = direct ? kji_pkg::ST_OUT : kji_pkg::ST_MUL;
      end
      kji_pkg::ST_MUL: begin
        if (cnt == LAST_BIT) begin
          state_next = kji_pkg::ST_DIV;
        end
      end
      kji_pkg::ST_DIV: begin
        if (cnt == LAST_BIT) begin
          state_next = kji_pkg::ST_RES;
        end
      end
      kji_pkg::ST_RES: state_next = kji_pkg::ST_OUT;
      kji_pkg::ST_OUT: begin
        if (out_free) begin
          state_next = (joint == LAST_JOINT) ? kji_pkg::ST_IDLE : kji_pkg::ST_FETCH;
        end
      end
      default: state_next = kji_pkg::ST_IDLE;
    endcase
  end

  // Per-state strobes.
  always_comb begin
    s_axis_tready = 1'b0;
    rd_en         = 1'b0;
    out_load      = 1'b0;
    rd_phase      = PIW'(current_phase);
    unique case (state)
      kji_pkg::ST_IDLE: s_axis_tready = 1'b1;
      kji_pkg::ST_COPY_RD: begin
        rd_en    = 1'b1;
        rd_phase = PIW'(current_phase - 1'b1);
      end
      kji_pkg::ST_FETCH: begin
        rd_en    = 1'b1;
        rd_phase = hold ? PIW'(count_sat - 1'b1) : PIW'(current_phase);
      end
      kji_pkg::ST_OUT: out_load = out_free;
      default: begin
        s_axis_tready = 1'b0;
      end
    endcase
  end

  assign rd_addr = {rd_phase, joint};

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= kji_pkg::ST_IDLE;
      phase_count      <= kji_pkg::PHASE_COUNT_RESET;
      current_phase    <= '0;
      phase_start_time <= '0;
      m_axis_tvalid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        phase_count <= cfg_wr_data;
      end
      // A start item restarts the trajectory at phase 0.
      if (accept && s_axis_tuser == kji_pkg::ACT_START) begin
        current_phase    <= '0;
        phase_start_time <= TW'(in_time);
      end
      // Phase advance when the elapsed time runs past the duration.
      if (state == kji_pkg::ST_EVAL && !past_end && overrun) begin
        current_phase <= cur_plus;
        if (!finishing) begin
          phase_start_time <= tick_time;
        end
      end
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // Keyframe memory: one write port for loads, one registered read port.
  always_ff @(posedge clk) begin
    if (accept && s_axis_tuser == kji_pkg::ACT_LOAD_KEY && phase_ok && joint_ok) begin
      kf_mem[{PIW'(in_phase), JIW'(in_joint)}] <= in_angle;
    end
    if (rd_en) begin
      rd_data <= kf_mem[rd_addr];
    end
  end

  // Duration table.
  always_ff @(posedge clk) begin
    if (accept && s_axis_tuser == kji_pkg::ACT_LOAD_DUR && phase_ok) begin
      durations[PIW'(in_phase)] <= TW'(in_dur);
    end
  end

  // Start pose: loaded directly or copied from the finished keyframe.
  always_ff @(posedge clk) begin
    if (accept && s_axis_tuser == kji_pkg::ACT_LOAD_START && joint_ok) begin
      start_pose[JIW'(in_joint)] <= in_angle;
    end else if (state == kji_pkg::ST_COPY_WR) begin
      start_pose[joint] <= rd_data;
    end
  end

  // Interpolation datapath and output register.
  always_ff @(posedge clk) begin
    if (accept) begin
      tick_time <= TW'(in_time);
    end
    unique case (state)
      kji_pkg::ST_EVAL: begin
        hold    <= past_end || (overrun && finishing);
        elapsed <= overrun ? '0 : elapsed_now;
        joint   <= '0;
      end
      kji_pkg::ST_COPY_WR: begin
        joint <= (joint == LAST_JOINT) ? '0 : joint + 1'b1;
      end
      kji_pkg::ST_LOAD: begin
        if (direct) begin
          res_angle <= hold ? rd_data : start_pose[joint];
        end else begin
          hi  <= '0;
          lo  <= abs_diff;
          neg <= diff[AW];
          cnt <= '0;
        end
      end
      kji_pkg::ST_MUL: begin
        // Multiplier bits leave at the bottom while product bits enter at the top.
        hi  <= mul_sum[TW:1];
        lo  <= {mul_sum[0], lo[AW-1:1]};
        cnt <= (cnt == LAST_BIT) ? '0 : cnt + 1'b1;
      end
      kji_pkg::ST_DIV: begin
        // Dividend bits leave at the top while quotient bits enter at the bottom.
        hi  <= div_ge ? div_r[TW-1:0] : div_t[TW-1:0];
        lo  <= {lo[AW-2:0], div_ge};
        cnt <= cnt + 1'b1;
      end
      kji_pkg::ST_RES: begin
        res_angle <= neg ? start_pose[joint] - lo : start_pose[joint] + lo;
      end
      kji_pkg::ST_OUT: begin
        if (out_free) begin
          out_id       <= kji_pkg::JOINT_ID_W'(joint);
          out_angle    <= res_angle;
          m_axis_tlast <= joint == LAST_JOINT;
          joint        <= (joint == LAST_JOINT) ? '0 : joint + 1'b1;
        end
      end
      default: begin
        hold <= hold;
      end
    endcase
  end

  assign m_axis_tdata = M_DATA_W'({out_angle, out_id});

endmodule

>>> rtl/core/kji_port_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyframe joint interpolator port checker
// Watches the stream ports of the interpolator and checks result ordering,
// framing against accepted ticks, output hold under stall and reset.
// ----------------------------------------------------------------------------
module kji_port_checker #(
  parameter int M_DATA_W = 24
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic [kji_pkg::ACTION_W-1:0]  s_axis_tuser,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [M_DATA_W-1:0]           m_axis_tdata,
  input logic                          m_axis_tlast
);

  logic [1:0]                     open_ticks;
  logic [kji_pkg::JOINT_ID_W-1:0] exp_id;
  logic                           tick_in;
  logic                           out_xfer;
  logic                           last_xfer;

  assign tick_in   = s_axis_tvalid && s_axis_tready && s_axis_tuser == kji_pkg::ACT_TICK;
  assign out_xfer  = m_axis_tvalid && m_axis_tready;
  assign last_xfer = out_xfer && m_axis_tlast;

  // Ticks taken whose last result has not yet been transferred. A new tick
  // may be taken while the last result of the previous one still waits.
  always_ff @(posedge clk) begin
    if (rst) begin
      open_ticks <= '0;
    end else if (tick_in && !last_xfer) begin
      open_ticks <= open_ticks + 1'b1;
    end else if (!tick_in && last_xfer) begin
      open_ticks <= open_ticks - 1'b1;
    end
  end

  // Expected joint number of the next result.
  always_ff @(posedge clk) begin
    if (rst) begin
      exp_id <= '0;
    end else if (out_xfer) begin
      exp_id <= m_axis_tlast ? '0 : exp_id + 1'b1;
    end
  end

  // Results come in joint order, restarting after each last result.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[kji_pkg::JOINT_ID_W-1:0] == exp_id)
    else $error("result joint number out of order");

  // No new item is taken while a tick still owes results.
  assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> open_ticks == 2'd0 ||
      (open_ticks == 2'd1 && m_axis_tvalid && m_axis_tlast))
    else $error("input taken while a tick is still open");

  // A result that is not the last one belongs to an open tick.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tlast |-> open_ticks != 2'd0)
    else $error("result without an open tick");

  // A stalled result holds.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // Reset empties the output.
  assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

endmodule

bind keyframe_joint_interpolator kji_port_checker #(
  .M_DATA_W(M_DATA_W)
) u_port_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

>>> verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyframe joint interpolator testbench
// Loads every keyframe, duration and start angle, then walks a table of
// corner cases: full-scale swings, zero-length phases, a finished trajectory,
// spare action codes and a wrapping clock. After that it plays random
// trajectories under several phase counts and idle patterns. The eight angles
// of each tick are predicted here and checked transfer by transfer.
// ----------------------------------------------------------------------------
module tb;
  import kji_pkg::*;

  localparam int JOINTS     = 8;
  localparam int PHASES     = 8;
  localparam int ANGLE_W    = 16;
  localparam int S_FIELDS_W = 2 * INDEX_W + ANGLE_W + DUR_IN_W + TIME_IN_W;
  localparam int S_DATA_W   = ((S_FIELDS_W + 7) / 8) * 8;
  localparam int M_DATA_W   = ((JOINT_ID_W + ANGLE_W + 7) / 8) * 8;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 16;
  localparam int END_QUIET     = 400;
  localparam int HOLD_CYCLES   = 600;
  localparam int OPS_PER_SET   = 28;
  localparam int SET_COUNT     = 6;

  // Action codes the block does not define; it must drop them.
  localparam logic [ACTION_W-1:0] ACT_SPARE_LO = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_SPARE_HI = 3'd7;

  // One input item; a pinned tick also carries a typed-in angle for the
  // joint named by joint_idx.
  typedef struct packed {
    logic [ACTION_W-1:0]  action;
    logic [INDEX_W-1:0]   phase_idx;
    logic [INDEX_W-1:0]   joint_idx;
    logic [ANGLE_W-1:0]   angle;
    logic [DUR_IN_W-1:0]  dur;
    logic [TIME_IN_W-1:0] tnow;
    logic                 pinned;
    logic [ANGLE_W-1:0]   pin_angle;
  } stim_t;

  typedef struct packed {
    logic [JOINT_ID_W-1:0] id;
    logic [ANGLE_W-1:0]    angle;
    logic                  last;
  } joint_cmd_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_wr_en = 1'b0;
  logic [PHASE_COUNT_W-1:0] cfg_wr_data = '0;
  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  // tdata: phase_index, joint_index, angle_value, duration_value, time_now
  logic [S_DATA_W-1:0]      s_axis_tdata = '0;
  // tuser: action
  logic [ACTION_W-1:0]      s_axis_tuser = '0;
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  // tdata: joint_id, joint_angle
  logic [M_DATA_W-1:0]      m_axis_tdata;
  logic                     m_axis_tlast;

  // Player state as the block should hold it.
  logic signed [ANGLE_W-1:0] key_angle [PHASES][JOINTS];
  logic [DUR_IN_W-1:0]       phase_len [PHASES];
  logic signed [ANGLE_W-1:0] pose_start [JOINTS];
  logic signed [ANGLE_W-1:0] pose_cmd [JOINTS];
  logic [3:0]                phase_now = '0;
  logic [TIME_IN_W-1:0]      phase_t0 = '0;
  logic [PHASE_COUNT_W-1:0]  cfg_phases = PHASE_COUNT_RESET;
  joint_cmd_t                cmd_expect_q [$];

  logic [TIME_IN_W-1:0]      play_clock = '0;
  int                        mismatch_count = 0;
  int unsigned               cycle_count = 0;
  int                        send_idle_pct = 30;
  int                        rcv_idle_pct = 70;
  bit                        hold_req = 1'b0;
  bit                        hold_taken = 1'b0;
  int                        hold_left = 0;

  logic [PHASE_COUNT_W-1:0] phase_sets [SET_COUNT] = '{4'd8, 4'd1, 4'd15, 4'd0, 4'd3, 4'd6};

  stim_t directed_rows [24] = '{
    // Full-scale swing on joint 0 over a 100-tick phase.
    '{ACT_LOAD_KEY,   3'd0, 3'd0, 16'h7FFF, 32'd0,   32'd0,    1'b0, 16'h0000},
    '{ACT_LOAD_START, 3'd0, 3'd0, 16'h8000, 32'd0,   32'd0,    1'b0, 16'h0000},
    '{ACT_LOAD_DUR,   3'd0, 3'd0, 16'h0000, 32'd100, 32'd0,    1'b0, 16'h0000},
    '{ACT_START,      3'd0, 3'd0, 16'h0000, 32'd0,   32'd1000, 1'b0, 16'h0000},
    // No time gone gives the start angle; elapsed equal to the duration
    // gives the keyframe, since the phase only moves on past it.
    '{ACT_TICK,       3'd0, 3'd0, 16'h0000, 32'd0,   32'd1000, 1'b1, 16'h8000},
    '{ACT_TICK,       3'd0, 3'd0, 16'h0000, 32'd0,   32'd1100, 1'b1, 16'h7FFF},
    // Halfway: 65535 * 50 / 100 truncates to 32767 above the start.
    '{ACT_TICK,       3'd0, 3'd0, 16'h0000, 32'd0,   32'd1050, 1'b1, 16'hFFFF},
    // A zero-length phase holds the pose it starts from.
    '{ACT_LOAD_DUR,   3'd1, 3'd0, 16'h0000, 32'd0,   32'd0,    1'b0, 16'h0000},
    '{ACT_TICK,       3'd0, 3'd0, 16'h0000, 32'd0,   32'd1101, 1'b1, 16'h7FFF},
    // Run out the remaining zero-length phases; past the end the last
    // keyframe holds.
    '{ACT_LOAD_KEY,   3'd4, 3'd5, 16'h04D2, 32'd0,   32'd0,    1'b0, 16'h0000},
    '{ACT_LOAD_DUR,   3'd2, 3'd0, 16'h0000, 32'd0,   32'd0,    1'b0, 16'h0000},
    '{ACT_LOAD_DUR,   3'd3, 3'd0, 16'h0000, 32'd0,   32'd0,    1'b0, 16'h0000},
    '{ACT_LOAD_DUR,   3'd4, 3'd0, 16'h0000, 32'd0,   32'd0,    1'b0, 16'h0000},
    '{ACT_TICK,       3'd0, 3'd0, 16'h0000, 32'd0,   32'd5000, 1'b0, 16'h0000},
    '{ACT_TICK,       3'd0, 3'd0, 16'h0000, 32'd0,   32'd5001, 1'b0, 16'h0000},
    '{ACT_TICK,       3'd0, 3'd0, 16'h0000, 32'd0,   32'd5002, 1'b0, 16'h0000},
    '{ACT_TICK,       3'd0, 3'd5, 16'h0000, 32'd0,   32'd5003, 1'b1, 16'h04D2},
    '{ACT_TICK,       3'd0, 3'd5, 16'h0000, 32'd0,   32'd5004, 1'b1, 16'h04D2},
    // Spare action codes are dropped.
    '{ACT_SPARE_LO,   3'd7, 3'd7, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 16'h0000},
    '{ACT_SPARE_HI,   3'd0, 3'd0, 16'h0000, 32'd0,   32'd0,    1'b0, 16'h0000},
    // Longest duration with the clock wrapping past zero.
    '{ACT_LOAD_DUR,   3'd0, 3'd0, 16'h0000, 32'hFFFF_FFFF, 32'd0, 1'b0, 16'h0000},
    '{ACT_START,      3'd0, 3'd0, 16'h0000, 32'd0,   32'hFFFF_FFF0, 1'b0, 16'h0000},
    '{ACT_TICK,       3'd0, 3'd0, 16'h0000, 32'd0,   32'h0000_0010, 1'b0, 16'h0000},
    '{ACT_TICK,       3'd0, 3'd0, 16'h0000, 32'd0,   32'hFFFF_FFEF, 1'b1, 16'h7FFF}
  };

  keyframe_joint_interpolator u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk = ~clk;

  // Update the player state for one item and, for a tick, work out the
  // commanded angle of every joint.
  task automatic advance_player(input stim_t it, output bit gives_cmds);
    int in_use, s, d, j;
    logic [TIME_IN_W-1:0] gap;
    longint unsigned span;
    gives_cmds = 1'b0;
    in_use = (cfg_phases == 0) ? 1 : (cfg_phases > PHASES) ? PHASES : int'(cfg_phases);
    case (it.action)
      ACT_LOAD_KEY:   key_angle[it.phase_idx][it.joint_idx] = it.angle;
      ACT_LOAD_START: pose_start[it.joint_idx] = it.angle;
      ACT_LOAD_DUR:   phase_len[it.phase_idx] = it.dur;
      ACT_START: begin
        phase_now = '0;
        phase_t0  = it.tnow;
      end
      ACT_TICK: begin
        gives_cmds = 1'b1;
        gap = it.tnow - phase_t0;
        // The phase moves on once the elapsed time runs past its duration.
        if (phase_now < in_use && gap > phase_len[phase_now]) begin
          phase_now = phase_now + 1'b1;
          if (phase_now < in_use) begin
            for (j = 0; j < JOINTS; j++)
              pose_start[j] = key_angle[phase_now - 1][j];
            phase_t0 = it.tnow;
            gap = '0;
          end
        end
        if (phase_now >= in_use) begin
          for (j = 0; j < JOINTS; j++)
            pose_cmd[j] = key_angle[in_use - 1][j];
        end else begin
          // Truncate the step toward the start angle.
          for (j = 0; j < JOINTS; j++) begin
            s = int'(pose_start[j]);
            d = int'(key_angle[phase_now][j]);
            if (phase_len[phase_now] == 0) begin
              pose_cmd[j] = ANGLE_W'(s);
            end else begin
              span = 64'((s <= d) ? d - s : s - d);
              span = span * gap / phase_len[phase_now];
              pose_cmd[j] = ANGLE_W'((s <= d) ? s + int'(span) : s - int'(span));
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  // Offer one item, wait for its transfer, then queue what it should cause.
  task automatic offer_item(input stim_t it);
    bit gives_cmds;
    int j;
    joint_cmd_t cmd;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.action;
    s_axis_tdata  <= S_DATA_W'({it.tnow, it.dur, it.angle, it.joint_idx, it.phase_idx});
    do @(posedge clk); while (!s_axis_tready);
    advance_player(it, gives_cmds);
    if (gives_cmds) begin
      if (it.pinned)
        pose_cmd[it.joint_idx] = it.pin_angle;
      for (j = 0; j < JOINTS; j++) begin
        cmd.id    = JOINT_ID_W'(j);
        cmd.angle = pose_cmd[j];
        cmd.last  = (j == JOINTS - 1);
        cmd_expect_q.insert(cmd_expect_q.size(), cmd);
      end
    end
  endtask

  // Stop offering and let every expected angle arrive.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (cmd_expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Output side: check each transfer and decide on ready for the next cycle.
  always @(posedge clk) begin : rx_side
    joint_cmd_t seen, want;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        seen = {m_axis_tdata[JOINT_ID_W-1:0], m_axis_tdata[JOINT_ID_W +: ANGLE_W],
                m_axis_tlast};
        if (cmd_expect_q.size() == 0) begin
          $display("%0t: unexpected transfer, expected none, actual joint %0d angle %0d",
                   $time, seen.id, $signed(seen.angle));
          mismatch_count++;
        end else begin
          want = cmd_expect_q.pop_front();
          if (seen.id != want.id) begin
            $display("%0t: joint_id mismatch, expected %0d, actual %0d",
                     $time, want.id, seen.id);
            mismatch_count++;
          end
          if (seen.angle != want.angle) begin
            $display("%0t: joint_angle mismatch on joint %0d, expected %0d, actual %0d",
                     $time, want.id, $signed(want.angle), $signed(seen.angle));
            mismatch_count++;
          end
          if (seen.last != want.last) begin
            $display("%0t: last_joint mismatch on joint %0d, expected %0b, actual %0b",
                     $time, want.id, want.last, seen.last);
            mismatch_count++;
          end
        end
      end
      // One long hold-off lets the block fill up and stall its input.
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
      end
    end
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    stim_t it;
    int set_idx, ops, roll, n, p, j;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Write every store once so that no tick reads an empty entry.
    for (p = 0; p < PHASES; p++) begin
      for (j = 0; j < JOINTS; j++) begin
        it = '0;
        it.action    = ACT_LOAD_KEY;
        it.phase_idx = INDEX_W'(p);
        it.joint_idx = INDEX_W'(j);
        it.angle     = ANGLE_W'($urandom);
        offer_item(it);
      end
    end
    for (j = 0; j < JOINTS; j++) begin
      it = '0;
      it.action    = ACT_LOAD_START;
      it.joint_idx = INDEX_W'(j);
      it.angle     = ANGLE_W'($urandom);
      offer_item(it);
    end
    for (p = 0; p < PHASES; p++) begin
      it = '0;
      it.action    = ACT_LOAD_DUR;
      it.phase_idx = INDEX_W'(p);
      it.dur       = $urandom_range(0, 60);
      offer_item(it);
    end

    // Corner cases at the reset phase count.
    for (n = 0; n < $size(directed_rows); n++)
      offer_item(directed_rows[n]);

    // Random trajectories, one phase count per set.
    for (set_idx = 0; set_idx < SET_COUNT; set_idx++) begin
      drain_results();
      cfg_wr_en   <= 1'b1;
      cfg_wr_data <= phase_sets[set_idx];
      @(posedge clk);
      cfg_wr_en   <= 1'b0;
      cfg_phases  = phase_sets[set_idx];
      send_idle_pct = (set_idx < 2) ? 30 : (set_idx < 4) ? 70 : 0;
      rcv_idle_pct  = (set_idx < 2) ? 70 : (set_idx < 4) ? 30 : 0;
      if (set_idx == 4)
        hold_req = 1'b1;
      ops = 0;
      while (ops < OPS_PER_SET) begin
        it = '0;
        {it.phase_idx, it.joint_idx} = 6'($urandom);
        it.angle = ANGLE_W'($urandom);
        it.dur   = $urandom;
        it.tnow  = $urandom;
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
          // Ticks mostly march forward; now and then the clock jumps anywhere.
          it.action = ACT_TICK;
          n = $urandom_range(0, 99);
          if (n < 5)
            play_clock = $urandom;
          else if (n < 15)
            play_clock = play_clock + $urandom_range(0, 500);
          else
            play_clock = play_clock + $urandom_range(0, 30);
          it.tnow = play_clock;
        end else if (roll < 73) begin
          it.action = ACT_LOAD_KEY;
          if ($urandom_range(0, 9) == 0)
            it.angle = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
        end else if (roll < 80) begin
          it.action = ACT_LOAD_START;
        end else if (roll < 90) begin
          it.action = ACT_LOAD_DUR;
          n = $urandom_range(0, 99);
          if (n < 10)
            it.dur = '0;
          else if (n < 70)
            it.dur = $urandom_range(1, 60);
          else if (n < 85)
            it.dur = $urandom_range(61, 2000);
        end else if (roll < 96) begin
          it.action = ACT_START;
          if ($urandom_range(0, 4) != 0)
            it.tnow = play_clock;
          else
            play_clock = it.tnow;
        end else begin
          it.action = ACTION_W'($urandom_range(ACT_SPARE_HI, ACT_SPARE_LO));
        end
        if (it.action <= ACT_TICK)
          ops++;
        offer_item(it);
      end
    end

    drain_results();
    repeat (END_QUIET) @(posedge clk);
    if (mismatch_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
